// ===== rtl/sfpp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpp_pkg
// Shared sizes, codes, beat types and helpers of the sharded free page pool.
// ----------------------------------------------------------------------------
package sfpp_pkg;

	localparam int SUB_LISTS = 8;
	localparam int SUB_DEPTH = 1024;
	localparam int PAGE_BITS = 16;

	localparam int LIST_W    = (SUB_LISTS > 1) ? $clog2(SUB_LISTS) : 1;
	localparam int SLOT_W    = $clog2(SUB_DEPTH);
	localparam int CNT_W     = $clog2(SUB_DEPTH + 1);
	localparam int POOL_W    = $clog2(SUB_LISTS * SUB_DEPTH + 1);
	localparam int ADDR_W    = LIST_W + SLOT_W;
	localparam int MEM_DEPTH = SUB_LISTS * (1 << SLOT_W);

	localparam logic KIND_FREE  = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [15:0] page;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] page_out;
		logic [13:0] total_free;
	} result_t;

	typedef struct packed {
		logic                 en;
		logic                 we;
		logic [ADDR_W-1:0]    addr;
		logic [PAGE_BITS-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        status;
		logic              from_mem;
		logic [POOL_W-1:0] total;
	} ctrl_res_t;

	function automatic logic [PAGE_BITS-1:0] page_to_store(input logic [15:0] p);
		logic [PAGE_BITS+15:0] wide;
		wide = {{PAGE_BITS{1'b0}}, p};
		return wide[PAGE_BITS-1:0];
	endfunction

	function automatic logic [15:0] store_to_page(input logic [PAGE_BITS-1:0] s);
		logic [PAGE_BITS+15:0] wide;
		wide = {16'b0, s};
		return wide[15:0];
	endfunction

	function automatic logic [13:0] pool_to_total(input logic [POOL_W-1:0] c);
		logic [POOL_W+13:0] wide;
		wide = {14'b0, c};
		return wide[13:0];
	endfunction

endpackage

// ===== rtl/sharded_free_page_pool_top.sv =====
// ----------------------------------------------------------------------------
// sharded_free_page_pool_top
// Pool of free page numbers kept in round-robin FIFO sub-lists.
// ----------------------------------------------------------------------------
// result beat: appears in the cycle after start is taken
// throughput: one item per cycle, busy stays low; the page store read of an
// allocate lands in the same cycle as its result
// reset: arst_n clears pointers, counts and the done strobe; the page store
// holds no reset value and is only read where a count says it was written
module sharded_free_page_pool_top
	import sfpp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	mem_req_t             mem_req;
	ctrl_res_t            res;
	logic [PAGE_BITS-1:0] rdata;
	logic                 accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	sfpp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.mem_req (mem_req),
		.res     (res)
	);

	sfpp_ram #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (PAGE_BITS)
	) u_ram (
		.clk   (clk),
		.en    (mem_req.en),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	always_comb begin
		done              = res.valid;
		result.status     = res.status;
		result.page_out   = res.from_mem ? store_to_page(rdata) : 16'b0;
		result.total_free = pool_to_total(res.total);
	end

endmodule

// ===== rtl/sfpp_ram.sv =====
// ----------------------------------------------------------------------------
// sfpp_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sfpp_ram #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sfpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfpp_ctrl
// Sub-list bookkeeping: round-robin pointers, per-list head, tail and count,
// rotating non-empty scan and page store access requests.
// ----------------------------------------------------------------------------
module sfpp_ctrl
	import sfpp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  item_t     item,
	output mem_req_t  mem_req,
	output ctrl_res_t res
);

	logic [SLOT_W-1:0] head_q [SUB_LISTS];
	logic [SLOT_W-1:0] tail_q [SUB_LISTS];
	logic [CNT_W-1:0]  cnt_q  [SUB_LISTS];
	logic [LIST_W-1:0] push_q;
	logic [LIST_W-1:0] pop_q;
	logic [POOL_W-1:0] pool_q;

	logic [1:0]        status_s1;
	logic              valid_s1;
	logic              from_mem_s1;
	logic [POOL_W-1:0] total_s1;

	logic [LIST_W-1:0] sel;
	logic [LIST_W:0]   cand;
	logic              full;
	logic              pool_empty;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(SUB_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [LIST_W-1:0] next_list(input logic [LIST_W-1:0] l);
		return (l == LIST_W'(SUB_LISTS - 1)) ? '0 : l + 1'b1;
	endfunction

	// rotating priority encoder: first non-empty list at or after pop_q
	always_comb begin
		sel  = pop_q;
		cand = '0;
		for (int k = SUB_LISTS - 1; k >= 0; k--) begin
			cand = {1'b0, pop_q} + (LIST_W + 1)'(k);
			if (cand >= (LIST_W + 1)'(SUB_LISTS)) begin
				cand = cand - (LIST_W + 1)'(SUB_LISTS);
			end
			if (cnt_q[cand[LIST_W-1:0]] != '0) begin
				sel = cand[LIST_W-1:0];
			end
		end
	end

	assign full       = (cnt_q[push_q] == CNT_W'(SUB_DEPTH));
	assign pool_empty = (pool_q == '0);

	always_comb begin
		mem_req       = '0;
		mem_req.wdata = page_to_store(item.page);
		if (item.kind == KIND_FREE) begin
			mem_req.addr = {push_q, tail_q[push_q]};
			mem_req.en   = accept && !full;
			mem_req.we   = 1'b1;
		end else begin
			mem_req.addr = {sel, head_q[sel]};
			mem_req.en   = accept && !pool_empty;
			mem_req.we   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SUB_LISTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			push_q      <= '0;
			pop_q       <= '0;
			pool_q      <= '0;
			valid_s1    <= 1'b0;
			status_s1   <= ST_DONE;
			from_mem_s1 <= 1'b0;
			total_s1    <= '0;
		end else begin
			valid_s1    <= accept;
			from_mem_s1 <= 1'b0;
			if (accept) begin
				if (item.kind == KIND_FREE) begin
					// pointer moves on even when the push is dropped
					push_q <= next_list(push_q);
					if (full) begin
						status_s1 <= ST_FULL;
						total_s1  <= pool_q;
					end else begin
						tail_q[push_q] <= next_slot(tail_q[push_q]);
						cnt_q[push_q]  <= cnt_q[push_q] + 1'b1;
						pool_q         <= pool_q + 1'b1;
						status_s1      <= ST_DONE;
						total_s1       <= pool_q + 1'b1;
					end
				end else begin
					if (pool_empty) begin
						status_s1 <= ST_EMPTY;
						total_s1  <= pool_q;
					end else begin
						pop_q        <= next_list(sel);
						head_q[sel]  <= next_slot(head_q[sel]);
						cnt_q[sel]   <= cnt_q[sel] - 1'b1;
						pool_q       <= pool_q - 1'b1;
						status_s1    <= ST_DONE;
						from_mem_s1  <= 1'b1;
						total_s1     <= pool_q - 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		res.valid    = valid_s1;
		res.status   = status_s1;
		res.from_mem = from_mem_s1;
		res.total    = total_s1;
	end

endmodule

// ===== rtl/sfpp_checker.sv =====
// ----------------------------------------------------------------------------
// sfpp_checker
// Port-level checks on the pool's result beats.
// ----------------------------------------------------------------------------
module sfpp_checker
	import sfpp_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// every taken item gives exactly one beat, in the next cycle
	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("no result beat after accepted item");

	a_no_stray_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result beat without an accepted item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_DONE || result.status == ST_EMPTY ||
			result.status == ST_FULL))
		else $error("undefined status code");

	a_fail_no_page: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_DONE) |-> (result.page_out == 16'b0))
		else $error("page returned on failed item");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |-> (result.total_free == 14'b0))
		else $error("empty status with pages in the pool");

endmodule

bind sharded_free_page_pool_top sfpp_checker u_sfpp_checker (.*);
